@@ design/tcp_pkg.sv @@
// ----------------------------------------------------------------------------
// tcp_pkg
// Shared types and constants for the telnet command parser: protocol bytes,
// option codes, parse phases, result kinds and the result-run record.
// ----------------------------------------------------------------------------
package tcp_pkg;

    // telnet command bytes
    localparam logic [7:0] B_SE   = 8'd240;
    localparam logic [7:0] B_SB   = 8'd250;
    localparam logic [7:0] B_WILL = 8'd251;
    localparam logic [7:0] B_WONT = 8'd252;
    localparam logic [7:0] B_DO   = 8'd253;
    localparam logic [7:0] B_DONT = 8'd254;
    localparam logic [7:0] B_IAC  = 8'd255;

    // telnet option codes
    localparam logic [7:0] OPT_ECHO   = 8'd1;
    localparam logic [7:0] OPT_SGA    = 8'd3;
    localparam logic [7:0] OPT_TTYPE  = 8'd24;
    localparam logic [7:0] OPT_NAWS   = 8'd31;
    localparam logic [7:0] OPT_TSPEED = 8'd32;
    localparam logic [7:0] OPT_LMODE  = 8'd34;

    // window size after reset
    localparam logic [15:0] COLS_RESET  = 16'd80;
    localparam logic [15:0] LINES_RESET = 16'd30;

    // result kinds
    localparam logic [1:0] KIND_DATA   = 2'd0;
    localparam logic [1:0] KIND_REPLY  = 2'd1;
    localparam logic [1:0] KIND_WINDOW = 2'd2;

    // last index of a run
    localparam logic [1:0] RUN_ONE   = 2'd0;
    localparam logic [1:0] RUN_THREE = 2'd2;

    // parse phases
    typedef enum logic [2:0] {
        PH_NORMAL = 3'd0,
        PH_IAC    = 3'd1,
        PH_OPT    = 3'd2,
        PH_SB     = 3'd3,
        PH_SBDAT  = 3'd4,
        PH_SBIAC  = 3'd5
    } t_phase;

    // all results caused by one received byte
    typedef struct packed {
        logic [1:0]       kind;
        logic [2:0][7:0]  bytes;
        logic [1:0]       last_idx;
        logic [15:0]      cols;
        logic [15:0]      lines;
    } t_run;

endpackage

@@ design/tcp_parser.sv @@
// ----------------------------------------------------------------------------
// tcp_parser
// Parse state machine. Consumes one byte per accepted transaction, tracks
// command and subnegotiation phases, keeps the window size and builds the
// run of results that the byte causes.
// ----------------------------------------------------------------------------
module tcp_parser #(
    parameter int SUBNEG_MAX_LEN = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_take,
    input  logic [7:0]    i_byte,
    output logic          o_run_valid,
    output tcp_pkg::t_run o_run
);

    localparam int CW = $clog2(SUBNEG_MAX_LEN + 1);

    tcp_pkg::t_phase r_phase, n_phase;
    logic [7:0]      r_held, n_held;
    logic [CW-1:0]   r_count, n_count;
    logic [3:0][7:0] r_head, n_head;
    logic [15:0]     r_cols, n_cols;
    logic [15:0]     r_lines, n_lines;

    logic            sb_store;
    logic [15:0]     naws_w;
    logic [15:0]     naws_h;
    logic            naws_hit;
    logic [7:0]      answer;
    logic            no_reply;

    assign naws_w = {r_head[0], r_head[1]};
    assign naws_h = {r_head[2], r_head[3]};
    assign naws_hit = (i_byte == tcp_pkg::B_SE) && (r_held == tcp_pkg::OPT_NAWS)
                   && (r_count == CW'(4));

    // reply choice for a verb and option
    always_comb begin
        no_reply = 1'b0;
        answer   = tcp_pkg::B_WONT;
        case (i_byte) inside
            tcp_pkg::OPT_ECHO, tcp_pkg::OPT_SGA, tcp_pkg::OPT_NAWS,
            tcp_pkg::OPT_LMODE: begin
                no_reply = 1'b1;
            end
            tcp_pkg::OPT_TTYPE, tcp_pkg::OPT_TSPEED: begin
                answer = tcp_pkg::B_DO;
            end
            default: begin
                if (r_held == tcp_pkg::B_WILL || r_held == tcp_pkg::B_WONT) begin
                    answer = tcp_pkg::B_DONT;
                end
            end
        endcase
    end

    // next phase
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            tcp_pkg::PH_IAC: begin
                if (i_byte inside {[tcp_pkg::B_WILL:tcp_pkg::B_DONT]}) begin
                    n_phase = tcp_pkg::PH_OPT;
                end else if (i_byte == tcp_pkg::B_SB) begin
                    n_phase = tcp_pkg::PH_SB;
                end else begin
                    n_phase = tcp_pkg::PH_NORMAL;
                end
            end
            tcp_pkg::PH_OPT:   n_phase = tcp_pkg::PH_NORMAL;
            tcp_pkg::PH_SB:    n_phase = tcp_pkg::PH_SBDAT;
            tcp_pkg::PH_SBDAT: begin
                if (i_byte == tcp_pkg::B_IAC) n_phase = tcp_pkg::PH_SBIAC;
            end
            tcp_pkg::PH_SBIAC: begin
                n_phase = (i_byte == tcp_pkg::B_IAC) ? tcp_pkg::PH_SBDAT
                                                     : tcp_pkg::PH_NORMAL;
            end
            default: begin
                n_phase = (i_byte == tcp_pkg::B_IAC) ? tcp_pkg::PH_IAC
                                                     : tcp_pkg::PH_NORMAL;
            end
        endcase
    end

    // subnegotiation data byte, plain or escaped
    assign sb_store = ((r_phase == tcp_pkg::PH_SBDAT) && (i_byte != tcp_pkg::B_IAC))
                   || ((r_phase == tcp_pkg::PH_SBIAC) && (i_byte == tcp_pkg::B_IAC));

    // held code, counter, head bytes and window size
    always_comb begin
        n_held  = r_held;
        n_count = r_count;
        n_head  = r_head;
        n_cols  = r_cols;
        n_lines = r_lines;
        if (r_phase == tcp_pkg::PH_IAC
                && i_byte inside {[tcp_pkg::B_WILL:tcp_pkg::B_DONT]}) begin
            n_held = i_byte;
        end
        if (r_phase == tcp_pkg::PH_SB) begin
            n_held  = i_byte;
            n_count = '0;
        end
        if (sb_store && r_count < CW'(SUBNEG_MAX_LEN)) begin
            if (r_count < CW'(4)) n_head[r_count[1:0]] = i_byte;
            n_count = r_count + CW'(1);
        end
        if (r_phase == tcp_pkg::PH_SBIAC && naws_hit) begin
            if (naws_w != 16'd0) n_cols  = naws_w;
            if (naws_h != 16'd0) n_lines = naws_h;
        end
    end

    // result run for this byte
    always_comb begin
        o_run_valid    = 1'b0;
        o_run.kind     = tcp_pkg::KIND_DATA;
        o_run.bytes    = {8'd0, 8'd0, i_byte};
        o_run.last_idx = tcp_pkg::RUN_ONE;
        o_run.cols     = n_cols;
        o_run.lines    = n_lines;
        case (r_phase)
            tcp_pkg::PH_IAC: begin
                o_run_valid = (i_byte == tcp_pkg::B_IAC);
            end
            tcp_pkg::PH_OPT: begin
                o_run_valid    = !no_reply;
                o_run.kind     = tcp_pkg::KIND_REPLY;
                o_run.bytes    = {i_byte, answer, tcp_pkg::B_IAC};
                o_run.last_idx = tcp_pkg::RUN_THREE;
            end
            tcp_pkg::PH_SB, tcp_pkg::PH_SBDAT: begin
                o_run_valid = 1'b0;
            end
            tcp_pkg::PH_SBIAC: begin
                o_run_valid = naws_hit;
                o_run.kind  = tcp_pkg::KIND_WINDOW;
                o_run.bytes = '0;
            end
            default: begin
                o_run_valid = (i_byte != tcp_pkg::B_IAC);
            end
        endcase
        o_run_valid = o_run_valid && i_take;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= tcp_pkg::PH_NORMAL;
            r_held  <= 8'd0;
            r_count <= '0;
            r_cols  <= tcp_pkg::COLS_RESET;
            r_lines <= tcp_pkg::LINES_RESET;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_held  <= n_held;
            r_count <= n_count;
            r_cols  <= n_cols;
            r_lines <= n_lines;
        end
    end

    // head bytes, no reset
    always_ff @(posedge i_clk) begin
        if (i_take) r_head <= n_head;
    end

endmodule

@@ design/tcp_run_queue.sv @@
// ----------------------------------------------------------------------------
// tcp_run_queue
// Two-entry queue of result runs. Serializes each run into one output
// transaction per result and flags the final result of each run.
// ----------------------------------------------------------------------------
module tcp_run_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tcp_pkg::t_run i_run,
    output logic          o_full,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [1:0]    o_kind,
    output logic [7:0]    o_byte,
    output logic [15:0]   o_cols,
    output logic [15:0]   o_lines,
    output logic          o_last
);

    tcp_pkg::t_run r_ent [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_count;
    logic [1:0]    r_idx;
    logic          pop_res;
    logic          pop_run;
    tcp_pkg::t_run head;

    assign head    = r_ent[r_rd_ptr];
    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_kind  = head.kind;
    assign o_byte  = head.bytes[r_idx];
    assign o_cols  = head.cols;
    assign o_lines = head.lines;
    assign o_last  = (r_idx == head.last_idx);
    assign pop_res = o_valid && !i_stall;
    assign pop_run = pop_res && o_last;

    // pointers, fill count and result index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
            r_idx    <= 2'd0;
        end else begin
            if (i_push) r_wr_ptr <= !r_wr_ptr;
            if (pop_run) r_rd_ptr <= !r_rd_ptr;
            if (i_push && !pop_run) begin
                r_count <= r_count + 2'd1;
            end else if (pop_run && !i_push) begin
                r_count <= r_count - 2'd1;
            end
            if (pop_run) begin
                r_idx <= 2'd0;
            end else if (pop_res) begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    // run storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_ent[r_wr_ptr] <= i_run;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("run queue count out of range");
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_idx <= head.last_idx)
        else $error("result index beyond end of run");
    a_idx_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop_res && !o_last) |=> (o_valid && r_idx == $past(r_idx) + 2'd1))
        else $error("run did not advance to next result");
    a_idx_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> r_idx == 2'd0)
        else $error("result index not cleared when empty");
`endif

endmodule

@@ design/telnet_command_parser.sv @@
// ----------------------------------------------------------------------------
// telnet_command_parser
// Receive-side telnet parser: passes data bytes through, answers option
// negotiation with three-byte replies and applies window size updates.
// ----------------------------------------------------------------------------
// Output: results of a taken byte are registered in the run queue, then offered.
// Throughput: one byte per cycle; a reply occupies three output transactions,
// and the two-run output queue stalls the input only when it is full.
// Reset: synchronous, active low; parse phase normal, window 80 by 30, queue empty.
module telnet_command_parser #(
    parameter int SUBNEG_MAX_LEN = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rx_valid,
    output logic        o_rx_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_out_kind,
    output logic [7:0]  o_out_byte,
    output logic [15:0] o_window_cols,
    output logic [15:0] o_window_lines,
    output logic        o_last_of_run
);

    logic          rx_take;
    logic          run_valid;
    tcp_pkg::t_run run;
    logic          q_full;

    // input transaction
    assign rx_take    = i_rx_valid && !q_full;
    assign o_rx_stall = q_full;

    tcp_parser #(
        .SUBNEG_MAX_LEN(SUBNEG_MAX_LEN)
    ) u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (rx_take),
        .i_byte     (i_rx_byte),
        .o_run_valid(run_valid),
        .o_run      (run)
    );

    tcp_run_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (run_valid),
        .i_run  (run),
        .o_full (q_full),
        .o_valid(o_out_valid),
        .i_stall(i_out_stall),
        .o_kind (o_out_kind),
        .o_byte (o_out_byte),
        .o_cols (o_window_cols),
        .o_lines(o_window_lines),
        .o_last (o_last_of_run)
    );

endmodule

@@ sim/telnet_result_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// telnet_result_checker
// Watches the byte and result channels of the telnet parser, predicts each
// result from the accepted byte stream and compares the results field by field.
// ----------------------------------------------------------------------------
module telnet_result_checker #(
    parameter int SUBNEG_MAX_LEN = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rx_valid,
    input  logic        i_rx_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [1:0]  i_out_kind,
    input  logic [7:0]  i_out_byte,
    input  logic [15:0] i_window_cols,
    input  logic [15:0] i_window_lines,
    input  logic        i_last_of_run,
    output int          o_fail_count,
    output int          o_pending_count
);

    import tcp_pkg::*;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  value;
        logic [15:0] cols;
        logic [15:0] lines;
        logic        last;
    } t_parsed_result;

    // predicted parser state
    t_phase      parse_phase;
    logic [7:0]  held_code;
    logic [8:0]  block_len;
    logic [7:0]  block_head [4];
    logic [15:0] cols_now;
    logic [15:0] lines_now;

    t_parsed_result expected_results [$];
    int             fail_total = 0;

    // one byte of subnegotiation payload, count saturates
    task automatic note_block_byte(input logic [7:0] c);
        if (block_len < SUBNEG_MAX_LEN) begin
            if (block_len < 4)
                block_head[block_len[1:0]] = c;
            block_len = block_len + 9'd1;
        end
    endtask

    // advance the parser by one byte and queue the results it causes
    task automatic predict_byte(input logic [7:0] c);
        logic [1:0]     kinds [3];
        logic [7:0]     values [3];
        logic [7:0]     answer;
        logic [15:0]    w;
        logic [15:0]    h;
        int             n;
        t_parsed_result r;
        n = 0;
        answer = B_WONT;
        case (parse_phase)
            PH_IAC: begin
                if (c == B_IAC) begin
                    kinds[0] = KIND_DATA;
                    values[0] = c;
                    n = 1;
                    parse_phase = PH_NORMAL;
                end else if (c >= B_WILL && c <= B_DONT) begin
                    held_code = c;
                    parse_phase = PH_OPT;
                end else if (c == B_SB) begin
                    parse_phase = PH_SB;
                end else begin
                    parse_phase = PH_NORMAL;
                end
            end
            PH_OPT: begin
                n = 3;
                case (c)
                    OPT_ECHO, OPT_SGA, OPT_NAWS, OPT_LMODE: n = 0;
                    OPT_TTYPE, OPT_TSPEED: answer = B_DO;
                    default: answer = (held_code == B_WILL || held_code == B_WONT) ?
                                      B_DONT : B_WONT;
                endcase
                kinds[0] = KIND_REPLY;
                kinds[1] = KIND_REPLY;
                kinds[2] = KIND_REPLY;
                values[0] = B_IAC;
                values[1] = answer;
                values[2] = c;
                parse_phase = PH_NORMAL;
            end
            PH_SB: begin
                held_code = c;
                block_len = '0;
                parse_phase = PH_SBDAT;
            end
            PH_SBDAT: begin
                if (c == B_IAC)
                    parse_phase = PH_SBIAC;
                else
                    note_block_byte(c);
            end
            PH_SBIAC: begin
                if (c == B_IAC) begin
                    note_block_byte(c);
                    parse_phase = PH_SBDAT;
                end else begin
                    // window size block of exactly four bytes
                    if (c == B_SE && held_code == OPT_NAWS && block_len == 9'd4) begin
                        w = {block_head[0], block_head[1]};
                        h = {block_head[2], block_head[3]};
                        if (w != 16'd0) cols_now = w;
                        if (h != 16'd0) lines_now = h;
                        kinds[0] = KIND_WINDOW;
                        values[0] = 8'd0;
                        n = 1;
                    end
                    parse_phase = PH_NORMAL;
                end
            end
            default: begin
                if (c == B_IAC) begin
                    parse_phase = PH_IAC;
                end else begin
                    kinds[0] = KIND_DATA;
                    values[0] = c;
                    n = 1;
                    parse_phase = PH_NORMAL;
                end
            end
        endcase
        for (int k = 0; k < n; k++) begin
            r.kind = kinds[k];
            r.value = values[k];
            r.cols = cols_now;
            r.lines = lines_now;
            r.last = (k == n - 1);
            expected_results.push_back(r);
        end
    endtask

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            fail_total++;
        end
    endtask

    // compare results first so an unexpected one is not masked by a new byte
    always @(posedge i_clk) begin
        t_parsed_result want;
        if (!i_rst_n) begin
            parse_phase = PH_NORMAL;
            held_code = '0;
            block_len = '0;
            for (int k = 0; k < 4; k++)
                block_head[k] = '0;
            cols_now = COLS_RESET;
            lines_now = LINES_RESET;
            expected_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result with none expected, kind %0d byte %0d",
                             $time, i_out_kind, i_out_byte);
                    fail_total++;
                end else begin
                    want = expected_results.pop_front();
                    compare_field("out_kind", 16'(want.kind), 16'(i_out_kind));
                    compare_field("out_byte", 16'(want.value), 16'(i_out_byte));
                    compare_field("window_cols", want.cols, i_window_cols);
                    compare_field("window_lines", want.lines, i_window_lines);
                    compare_field("last_of_run", 16'(want.last), 16'(i_last_of_run));
                end
            end
            if (i_rx_valid && !i_rx_stall)
                predict_byte(i_rx_byte);
        end
        o_pending_count <= expected_results.size();
        o_fail_count <= fail_total;
    end

endmodule

@@ sim/telnet_command_parser_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// telnet_command_parser_test
// Drives a telnet byte stream into the parser: a directed opening, then random
// data, negotiations and subnegotiation blocks with random idling on both
// channels. The checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module telnet_command_parser_test;

    import tcp_pkg::*;

    localparam int SUBNEG_LIMIT  = 256;
    localparam int RANDOM_BYTES  = 444;
    localparam int QUIET_BYTES   = 60;
    localparam int LONG_AT       = 100;
    localparam int DRAIN_CYCLES  = 8;
    localparam int STUCK_LIMIT   = 2000;
    localparam int OPENING_COUNT = 26;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        rx_valid = 1'b0;
    logic        rx_stall;
    logic [7:0]  rx_byte = 8'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  out_kind;
    logic [7:0]  out_byte;
    logic [15:0] window_cols;
    logic [15:0] window_lines;
    logic        last_of_run;
    int          fail_count;
    int          pending_count;

    bit          gaps_on = 1'b1;
    int          bytes_sent = 0;
    int          quiet_cycles = 0;
    logic [7:0]  opening_bytes [OPENING_COUNT];

    always #6 clk = ~clk;

    telnet_command_parser #(
        .SUBNEG_MAX_LEN(SUBNEG_LIMIT)
    ) dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_rx_valid     (rx_valid),
        .o_rx_stall     (rx_stall),
        .i_rx_byte      (rx_byte),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_out_kind     (out_kind),
        .o_out_byte     (out_byte),
        .o_window_cols  (window_cols),
        .o_window_lines (window_lines),
        .o_last_of_run  (last_of_run)
    );

    telnet_result_checker #(
        .SUBNEG_MAX_LEN(SUBNEG_LIMIT)
    ) result_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_rx_valid      (rx_valid),
        .i_rx_stall      (rx_stall),
        .i_rx_byte       (rx_byte),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_out_kind      (out_kind),
        .i_out_byte      (out_byte),
        .i_window_cols   (window_cols),
        .i_window_lines  (window_lines),
        .i_last_of_run   (last_of_run),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count)
    );

    // one byte transaction, optionally after an idle burst
    task automatic send_byte(input logic [7:0] b);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            rx_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte <= b;
        do @(posedge clk); while (rx_stall);
        bytes_sent++;
    endtask

    // payload byte, doubled when it is IAC
    task automatic send_escaped(input logic [7:0] b);
        send_byte(b);
        if (b == B_IAC)
            send_byte(b);
    endtask

    // IAC SB opt payload IAC SE, or a broken end
    task automatic send_block(input logic [7:0] opt, input int len, input bit good_end);
        logic [7:0] b;
        send_byte(B_IAC);
        send_byte(B_SB);
        send_byte(opt);
        for (int i = 0; i < len; i++) begin
            b = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
            send_escaped(b);
        end
        send_byte(B_IAC);
        if (good_end) begin
            send_byte(B_SE);
        end else begin
            b = 8'($urandom_range(0, 253));
            if (b >= B_SE)
                b = b + 8'd1;
            send_byte(b);
        end
    endtask

    // output side idling in bursts
    initial begin
        forever begin
            @(posedge clk);
            if (gaps_on && $urandom_range(0, 5) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge clk) begin
        if (!rst_n || (rx_valid && !rx_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STUCK_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int         stop_at;
        int         next_switch;
        bit         long_done;
        logic [7:0] b;
        logic [7:0] opt;
        stop_at = OPENING_COUNT + RANDOM_BYTES;
        next_switch = OPENING_COUNT + 80;
        long_done = 1'b0;
        opening_bytes = '{
            8'h00,
            B_IAC, B_IAC,
            B_IAC, B_WILL, OPT_ECHO,
            B_IAC, B_DO, OPT_TTYPE,
            B_IAC, B_WONT, 8'h00,
            B_IAC, B_DONT, 8'hFF,
            B_IAC, 8'hF1,
            B_IAC, B_SB, OPT_NAWS, 8'h00, 8'h00, 8'h00, 8'h00, B_IAC, B_SE
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed opening: data extremes, each reply, dropped command, zero window
        for (int i = 0; i < OPENING_COUNT; i++)
            send_byte(opening_bytes[i]);

        // random sequences
        while (bytes_sent < stop_at) begin
            if (bytes_sent >= stop_at - QUIET_BYTES) begin
                gaps_on = 1'b0;
            end else if (bytes_sent >= next_switch) begin
                gaps_on = ($urandom_range(0, 3) != 0);
                next_switch += 80;
            end
            if (!long_done && bytes_sent >= LONG_AT) begin
                // saturating window block
                send_block(OPT_NAWS, SUBNEG_LIMIT + 4, 1'b1);
                long_done = 1'b1;
            end else begin
                case ($urandom_range(0, 15))
                    0, 1, 2, 3, 4: send_byte(8'($urandom_range(0, 254)));
                    5: begin
                        send_byte(B_IAC);
                        send_byte(B_IAC);
                    end
                    6, 7, 8, 9: begin
                        if ($urandom_range(0, 1) == 0) begin
                            case ($urandom_range(0, 5))
                                0: opt = OPT_ECHO;
                                1: opt = OPT_SGA;
                                2: opt = OPT_TTYPE;
                                3: opt = OPT_NAWS;
                                4: opt = OPT_TSPEED;
                                default: opt = OPT_LMODE;
                            endcase
                        end else begin
                            opt = 8'($urandom_range(0, 255));
                        end
                        send_byte(B_IAC);
                        send_byte(B_WILL + 8'($urandom_range(0, 3)));
                        send_byte(opt);
                    end
                    10, 11, 12: send_block(OPT_NAWS,
                                           ($urandom_range(0, 3) == 0) ?
                                           $urandom_range(0, 7) : 4,
                                           $urandom_range(0, 7) != 0);
                    13: send_block(8'($urandom_range(0, 255)), $urandom_range(0, 6),
                                   $urandom_range(0, 5) != 0);
                    14: begin
                        // command byte that is neither IAC, a verb nor SB
                        b = 8'($urandom_range(0, 249));
                        send_byte(B_IAC);
                        send_byte(b);
                    end
                    default: send_byte(8'($urandom_range(0, 255)));
                endcase
            end
        end

        // drain and verdict
        rx_valid <= 1'b0;
        do @(posedge clk); while (pending_count != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ filelist.f @@
design/tcp_pkg.sv
design/tcp_parser.sv
design/tcp_run_queue.sv
design/telnet_command_parser.sv
sim/telnet_result_checker.sv
sim/telnet_command_parser_test.sv
